/* hw/rtl/lsbp_pkg.sv */
// Package for the LSB-first bit packer: request and result payload types,
// internal job and config structs, status/operation/register codes.
// No dependencies.
`default_nettype none

package lsbp_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned JQ_DEPTH    = 4;
  localparam int unsigned JQ_PTR_W    = 2;
  localparam int unsigned JQ_CNT_W    = 3;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PAD   = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_STRAY     = 3'd2;
  localparam logic [2:0] ST_LIMIT     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_LIMIT    = 2'd1;

  typedef struct packed {
    logic        operation;
    logic [5:0]  write_len;
    logic [63:0] field_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic                  limit_enable;
    logic [CFG_DATA_W-1:0] bit_limit;
  } cfg_t;

  // One classified request: bytes to emit (0 means a single status result).
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [3:0]           nbytes;
    logic [2:0]           status;
  } job_t;

endpackage

`default_nettype wire

/* hw/rtl/lsbp_front.sv */
// Front end of the bit packer: holds stream state, checks each request and
// turns it into a job for the back end. Depends on lsbp_pkg.
`default_nettype none

module lsbp_front import lsbp_pkg::*; #(
  parameter int unsigned MAX_WRITE_BITS = 56,
  parameter int unsigned COUNT_BITS     = 48
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     accept,
  input  wire in_item_t req,
  output job_t          job
);

  localparam int unsigned SUM_W = COUNT_BITS + 1;
  localparam int unsigned CMP_W = (SUM_W > CFG_DATA_W) ? SUM_W : CFG_DATA_W;
  localparam logic [5:0]  MAX_CNT = 6'(MAX_WRITE_BITS);

  logic [6:0]            partial_r, partial_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;

  logic [2:0]           rem;
  logic                 pad_aligned;
  logic [5:0]           cnt;
  logic [63:0]          val;
  logic [63:0]          mask;
  logic [SUM_W-1:0]     sum;
  logic                 too_large, stray, ovf, over_limit;
  logic [2:0]           status;
  logic [WORD_BITS-1:0] word, rest;
  logic [6:0]           bit_end;
  logic [3:0]           nbytes;

  always_comb begin
    rem         = total_r[2:0];
    pad_aligned = (req.operation == OP_PAD) && (rem == 3'd0);
    cnt         = (req.operation == OP_PAD) ? 6'(4'd8 - {1'b0, rem}) : req.write_len;
    val         = (req.operation == OP_PAD) ? 64'd0 : req.field_value;
    mask        = (64'd1 << cnt) - 64'd1;
    sum         = {1'b0, total_r} + SUM_W'(cnt);

    too_large  = cnt > MAX_CNT;
    stray      = (val & ~mask) != 64'd0;
    ovf        = sum[COUNT_BITS];
    over_limit = cfg.limit_enable && (CMP_W'(sum) > CMP_W'(cfg.bit_limit));

    if (pad_aligned)    status = ST_OK;
    else if (too_large) status = ST_TOO_LARGE;
    else if (stray)     status = ST_STRAY;
    else if (ovf)       status = ST_OVERFLOW;
    else if (over_limit) status = ST_LIMIT;
    else                status = ST_OK;

    word    = WORD_BITS'(partial_r) | (val << rem);
    bit_end = 7'(rem) + 7'(cnt);
    nbytes  = bit_end[6:3];
    rest    = word >> {nbytes, 3'b000};

    job.word   = word;
    job.nbytes = (pad_aligned || status != ST_OK) ? 4'd0 : nbytes;
    job.status = status;

    partial_nxt = partial_r;
    total_nxt   = total_r;
    if (accept && !pad_aligned && status == ST_OK) begin
      partial_nxt = rest[6:0];
      total_nxt   = sum[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      total_r   <= '0;
    end else begin
      partial_r <= partial_nxt;
      total_r   <= total_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lsbp_queue.sv */
// Short job queue between the front and back ends of the bit packer.
// Depends on lsbp_pkg.
`default_nettype none

module lsbp_queue import lsbp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  job_t                entry_r [JQ_DEPTH];
  logic [JQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JQ_CNT_W-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  always_comb begin
    full       = count_r == JQ_CNT_W'(JQ_DEPTH);
    empty      = count_r == '0;
    head       = entry_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + JQ_CNT_W'(do_push) - JQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lsbp_back.sv */
// Back end of the bit packer: walks the head job one result per cycle into
// the output register while it is free or popped. Depends on lsbp_pkg.
`default_nettype none

module lsbp_back import lsbp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_empty,
  input  wire job_t job,
  output logic      job_pop,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_item_t out_data
);

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       advance, is_last;
  logic [3:0] nres_m1;

  always_comb begin
    // a job with no bytes still gives one status result
    nres_m1 = (job.nbytes == 4'd0) ? 4'd0 : job.nbytes - 4'd1;
    is_last = {1'b0, idx_r} == nres_m1;
    advance = !job_empty && (!out_valid_r || out_pop);
    job_pop = advance && is_last;

    out_data_nxt = out_data_r;
    idx_nxt      = idx_r;
    if (advance) begin
      if (job.nbytes == 4'd0) begin
        out_data_nxt.out_byte   = 8'd0;
        out_data_nxt.byte_valid = 1'b0;
        out_data_nxt.status     = job.status;
      end else begin
        out_data_nxt.out_byte   = job.word[{idx_r, 3'b000} +: BYTE_BITS];
        out_data_nxt.byte_valid = 1'b1;
        out_data_nxt.status     = ST_OK;
      end
      out_data_nxt.last = is_last;
      idx_nxt           = is_last ? 3'd0 : idx_r + 3'd1;
    end

    if (advance)      out_valid_nxt = 1'b1;
    else if (out_pop) out_valid_nxt = 1'b0;
    else              out_valid_nxt = out_valid_r;

    out_empty = !out_valid_r;
    out_data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lsb_first_bit_packer_top.sv */
// LSB-first bit packer top level: config registers, front end, job queue,
// back end. Depends on lsbp_pkg, lsbp_front, lsbp_queue, lsbp_back.
// An accepted request goes into the 4-entry job queue, then via the back end into
// the output register. Requests enter one per cycle while the queue has room; the
// back end gives one result per cycle while results are popped: max(bytes, 1) per
// request, up to 7 for a 56-bit write. Synchronous reset clears control state.
`default_nettype none

module lsb_first_bit_packer_top import lsbp_pkg::*; #(
  parameter int unsigned MAX_WRITE_BITS = 56,
  parameter int unsigned COUNT_BITS     = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire in_item_t              in_data,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic in_accept, out_accept;
  job_t front_job, head_job;
  logic q_full, q_empty, q_pop;

  always_comb begin
    cfg_ready  = 1'b1;
    in_full    = q_full;
    in_accept  = in_push && !q_full;
    out_accept = out_pop && !out_empty;

    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_LIMIT_ENABLE: cfg_nxt.limit_enable = cfg_data[0];
        CFG_BIT_LIMIT:    cfg_nxt.bit_limit    = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lsbp_front #(
    .MAX_WRITE_BITS (MAX_WRITE_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (in_accept),
    .req    (in_data),
    .job    (front_job)
  );

  lsbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  lsbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (q_empty),
    .job       (head_job),
    .job_pop   (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_accept),
    .out_data  (out_data)
  );

  // a byte result always carries ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.byte_valid) |-> (out_data.status == ST_OK))
    else $error("byte result with non-ok status");

  // a result without a byte is the only result of its request
  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.byte_valid) |-> (out_data.last && out_data.out_byte == 8'd0))
    else $error("status result not marked last or nonzero byte");

  // the rest of a request's bytes follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_accept && !out_data.last) |=> !out_empty)
    else $error("gap inside a request's results");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Testbench for lsb_first_bit_packer_top: directed and random write/pad requests,
// results checked against a bit-level prediction of the packed byte stream.
// Depends on lsbp_pkg and the packer RTL.

module testbench;
  import lsbp_pkg::*;

  localparam int unsigned WRITE_MAX = 56;
  localparam int unsigned COUNTER_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 150;

  class stream_checker;
    bit                    limit_on;
    logic [CFG_DATA_W-1:0] limit_bits;
    logic [6:0]            partial_bits;
    logic [COUNTER_W-1:0]  bit_total;
    out_item_t             expected_results[$];
    int unsigned           fail_count;

    function new();
      limit_on = 0;
      limit_bits = '0;
      partial_bits = '0;
      bit_total = '0;
      fail_count = 0;
    endfunction

    task report(string msg);
      if (fail_count < 100) $display("ERROR @%0t: %s", $realtime, msg);
      fail_count++;
    endtask

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_LIMIT_ENABLE) limit_on = data[0];
      else if (idx == CFG_BIT_LIMIT) limit_bits = data;
    endfunction

    function void push_single(logic [2:0] code);
      out_item_t r;
      r.out_byte = '0;
      r.byte_valid = 1'b0;
      r.status = code;
      r.last = 1'b1;
      expected_results.push_back(r);
    endfunction

    function void append_bits(int unsigned cnt, logic [63:0] value);
      logic [COUNTER_W:0] end_total;
      logic [63:0] word;
      int unsigned rem;
      int unsigned nbytes;
      out_item_t r;
      end_total = {1'b0, bit_total} + (COUNTER_W+1)'(cnt);
      if (cnt > WRITE_MAX) push_single(ST_TOO_LARGE);
      else if ((value >> cnt) != 0) push_single(ST_STRAY);
      else if (end_total[COUNTER_W]) push_single(ST_OVERFLOW);
      else if (limit_on && end_total[COUNTER_W-1:0] > limit_bits) push_single(ST_LIMIT);
      else begin
        rem = int'(bit_total % BYTE_BITS);
        word = {57'd0, partial_bits} | (value << rem);
        nbytes = (rem + cnt) / BYTE_BITS;
        for (int unsigned k = 0; k < nbytes; k++) begin
          r.out_byte = word[k*8 +: 8];
          r.byte_valid = 1'b1;
          r.status = ST_OK;
          r.last = (k + 1 == nbytes);
          expected_results.push_back(r);
        end
        partial_bits = 7'(word >> (nbytes * 8));
        bit_total = end_total[COUNTER_W-1:0];
        if (nbytes == 0) push_single(ST_OK);
      end
    endfunction

    function void note_request(in_item_t req);
      int unsigned rem;
      rem = int'(bit_total % BYTE_BITS);
      if (req.operation == OP_PAD) begin
        // aligned pad: no checks, nothing written
        if (rem == 0) push_single(ST_OK);
        else append_bits(BYTE_BITS - rem, 64'd0);
      end else begin
        append_bits(req.write_len, req.field_value);
      end
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result byte=%h valid=%b status=%0d last=%b",
                         got.out_byte, got.byte_valid, got.status, got.last));
        return;
      end
      want = expected_results.pop_front();
      if (got !== want)
        report($sformatf("result byte=%h valid=%b status=%0d last=%b, want %h %b %0d %b",
                         got.out_byte, got.byte_valid, got.status, got.last,
                         want.out_byte, want.byte_valid, want.status, want.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  in_item_t              in_data = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stream_checker sb = new();
  bit          no_idle = 0;
  int unsigned stall_requests = 0;

  lsb_first_bit_packer_top #(
    .MAX_WRITE_BITS(WRITE_MAX),
    .COUNT_BITS(COUNTER_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random pops, plus a long hold-off whenever one is requested
  initial begin
    int unsigned stalls_seen;
    int unsigned stall_left;
    stalls_seen = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_result(out_data);
      @(negedge clk);
      if (stalls_seen != stall_requests) begin
        stalls_seen++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 35) begin
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // called at a falling edge; in_push stays high after the request so the
  // next one can follow without a gap
  task automatic send_request(input in_item_t item);
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_full);
    sb.note_request(item);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic in_item_t make_req(logic op, logic [5:0] cnt, logic [63:0] value);
    in_item_t r;
    r.operation = op;
    r.write_len = cnt;
    r.field_value = value;
    return r;
  endfunction

  task automatic run_random(input int unsigned n);
    in_item_t r;
    int unsigned sel;
    int unsigned cnt;
    logic [63:0] value;
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      value = {$urandom, $urandom};
      if (sel < 10) begin
        r = make_req(OP_PAD, 6'($urandom_range(0, 63)), value);
      end else if (sel < 80) begin
        cnt = $urandom_range(0, WRITE_MAX);
        value = (cnt == 0) ? 64'd0 : (value & ((64'd1 << cnt) - 64'd1));
        r = make_req(OP_WRITE, 6'(cnt), value);
      end else if (sel < 88) begin
        // well-formed value with one stray bit above the count
        cnt = $urandom_range(0, WRITE_MAX - 1);
        value = (cnt == 0) ? 64'd0 : (value & ((64'd1 << cnt) - 64'd1));
        value = value | (64'd1 << $urandom_range(cnt, 63));
        r = make_req(OP_WRITE, 6'(cnt), value);
      end else begin
        r = make_req(OP_WRITE, 6'($urandom_range(0, 63)), value);
      end
      send_request(r);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, limit off
    send_request(make_req(OP_WRITE, 6'd0, 64'd0));
    send_request(make_req(OP_WRITE, 6'd0, 64'd1));
    send_request(make_req(OP_WRITE, 6'd1, 64'd1));
    send_request(make_req(OP_PAD, 6'd0, 64'd0));
    send_request(make_req(OP_PAD, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_req(OP_WRITE, 6'd56, 64'h00FF_FFFF_FFFF_FFFF));
    send_request(make_req(OP_WRITE, 6'd3, 64'h5));
    send_request(make_req(OP_WRITE, 6'd56, 64'h00A5_3C96_0F1E_7788));
    send_request(make_req(OP_WRITE, 6'd57, 64'd0));
    send_request(make_req(OP_WRITE, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_req(OP_WRITE, 6'd5, 64'h20));
    send_request(make_req(OP_WRITE, 6'd56, 64'h8000_0000_0000_0001));
    send_request(make_req(OP_WRITE, 6'd5, 64'h1F));
    send_request(make_req(OP_WRITE, 6'd8, 64'hA5));
    send_request(make_req(OP_WRITE, 6'd7, 64'h7F));
    send_request(make_req(OP_WRITE, 6'd7, 64'h55));
    send_request(make_req(OP_PAD, 6'd0, 64'd0));
    drain();

    // limit of zero: only an aligned pad gets through
    write_reg(CFG_LIMIT_ENABLE, 48'd1);
    write_reg(CFG_BIT_LIMIT, 48'd0);
    send_request(make_req(OP_PAD, 6'd0, 64'd0));
    send_request(make_req(OP_WRITE, 6'd0, 64'd0));
    send_request(make_req(OP_WRITE, 6'd1, 64'd1));
    drain();

    write_reg(CFG_BIT_LIMIT, sb.bit_total + 48'd12);
    write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
    send_request(make_req(OP_WRITE, 6'd8, 64'h3C));
    send_request(make_req(OP_WRITE, 6'd5, 64'h1B));
    send_request(make_req(OP_WRITE, 6'd4, 64'hF));
    send_request(make_req(OP_PAD, 6'd0, 64'd0));
    send_request(make_req(OP_WRITE, 6'd0, 64'd0));
    drain();

    // random, limit off (enable bit clear in a mostly-ones word)
    write_reg(CFG_LIMIT_ENABLE, 48'hFFFF_FFFF_FFFE);
    write_reg(CFG_BIT_LIMIT, 48'hFFFF_FFFF_FFFF);
    stall_requests++;
    run_random(50);
    drain();

    // random near a tight limit, no idling on either side
    write_reg(CFG_LIMIT_ENABLE, 48'd1);
    write_reg(CFG_BIT_LIMIT, sb.bit_total + 48'($urandom_range(200, 600)));
    no_idle = 1;
    run_random(45);
    drain();
    no_idle = 0;

    // random at the largest limit
    write_reg(CFG_BIT_LIMIT, 48'hFFFF_FFFF_FFFF);
    stall_requests++;
    run_random(45);
    drain();

    repeat (20) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lsbp_pkg.sv
hw/rtl/lsbp_front.sv
hw/rtl/lsbp_queue.sv
hw/rtl/lsbp_back.sv
hw/rtl/lsb_first_bit_packer_top.sv
tb/testbench.sv
